// ===== design/scancode_key_state_typeahead_fifo_defines.svh =====
// Assertion macros for the checker file of the key-state type-ahead block.
`ifndef SCANCODE_KEY_STATE_TYPEAHEAD_FIFO_DEFINES_SVH
`define SCANCODE_KEY_STATE_TYPEAHEAD_FIFO_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SKTF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sktf_pkg.sv =====
// Types, codes and constants of the key-state type-ahead block.
package sktf_pkg;

  localparam int unsigned RingDepthDef = 15;

  localparam int unsigned ScanW  = 7;
  localparam int unsigned AsciiW = 8;
  localparam int unsigned ValueW = 9;
  localparam int unsigned CountW = 4;
  localparam int unsigned FlagW  = 5;
  localparam int unsigned EntryW = ScanW + AsciiW;
  localparam int unsigned InW    = 16;
  localparam int unsigned UserW  = 3;
  localparam int unsigned OutW   = 24;

  // direction flag bits
  localparam int unsigned FlagUp   = 0;
  localparam int unsigned FlagUpL  = 1;
  localparam int unsigned FlagUpR  = 2;
  localparam int unsigned FlagDown = 3;
  localparam int unsigned FlagRel  = 4;

  // scancodes
  localparam logic [ScanW-1:0] ScCtrl    = 7'h1d;
  localparam logic [ScanW-1:0] ScS       = 7'h1f;
  localparam logic [ScanW-1:0] ScHome    = 7'h47;
  localparam logic [ScanW-1:0] ScHomeAlt = 7'h58;
  localparam logic [ScanW-1:0] ScPgUp    = 7'h49;
  localparam logic [ScanW-1:0] ScUp      = 7'h48;
  localparam logic [ScanW-1:0] ScUpAlt   = 7'h29;
  localparam logic [ScanW-1:0] ScLeft    = 7'h4b;
  localparam logic [ScanW-1:0] ScLeftAlt = 7'h2b;
  localparam logic [ScanW-1:0] ScRight   = 7'h4d;
  localparam logic [ScanW-1:0] ScRghtAlt = 7'h4e;
  localparam logic [ScanW-1:0] ScDown    = 7'h50;
  localparam logic [ScanW-1:0] ScDownAlt = 7'h4a;
  localparam logic [ScanW-1:0] ScScroll  = 7'h46;
  localparam logic [ScanW-1:0] ScSysReq  = 7'h54;
  localparam logic [ScanW-1:0] ScLShift  = 7'h2a;
  localparam logic [ScanW-1:0] ScRShift  = 7'h36;
  localparam logic [ScanW-1:0] ScAlt     = 7'h38;
  localparam logic [ScanW-1:0] ScCaps    = 7'h3a;
  localparam logic [ScanW-1:0] ScNumLock = 7'h45;

  // register indexes
  localparam logic RegAlias = 1'b0;
  localparam logic RegChain = 1'b1;

  typedef enum logic [UserW-1:0] {
    OP_KEY     = 3'd0,
    OP_PEEK    = 3'd1,
    OP_POP     = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_INSTALL = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // decoder verdict for one key event
  typedef struct packed {
    logic [FlagW-1:0] flags;
    logic             ctrl;
    logic             want_queue;
    logic             toggle;
  } key_res_t;

  function automatic logic is_shift_key(logic [ScanW-1:0] sc);
    return (sc == ScCtrl) || (sc == ScLShift) || (sc == ScRShift) || (sc == ScAlt) ||
           (sc == ScCaps) || (sc == ScNumLock) || (sc == ScScroll);
  endfunction

endpackage

// ===== design/scancode_key_state_typeahead_fifo.sv =====
// Top level: keyboard key-state tracker with a type-ahead ring in a synchronous memory.
//
//  channel  | dir | handshake                    | payload (low bit first)
//  ---------+-----+------------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: operation; tdata: scan_code,
//           |     |                              |   key_down, ascii_code
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: key_value .. sound_toggle
//  cfg      | in  | cfg_we_i (no ready)          | cfg_idx_i, cfg_data_i
//
// Each word is handled in turn: the accept cycle reads the ring entry at the head,
// the execute cycle decodes, writes the ring at the tail and loads the result register.
// One word is in flight at a time; a new word is taken while the previous result waits.
// If the result register is still full at execute, the block holds in execute until
// m_axis_tready frees it. Reset empties the ring (head and count) with no clearing pass;
// ring entries are only ever used after being written.
module scancode_key_state_typeahead_fifo #(
  parameter int unsigned RingDepth = sktf_pkg::RingDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // slave side
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [sktf_pkg::InW-1:0]   s_axis_tdata,  // scan_code[6:0], key_down[7], ascii_code[15:8]
  input  logic [sktf_pkg::UserW-1:0] s_axis_tuser,  // operation[2:0]
  // master side
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [sktf_pkg::OutW-1:0]  m_axis_tdata,  // key_value[8:0], key_ready[9],
                                                    // entries_queued[13:10], entry_dropped[14],
                                                    // up_held[15], up_left_held[16],
                                                    // up_right_held[17], down_held[18],
                                                    // up_released[19], sound_toggle[20], 0[23:21]
  // configuration
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic                       cfg_data_i
);
  import sktf_pkg::*;

  localparam int unsigned IdxW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned CntW = $clog2(RingDepth + 1);
  localparam int unsigned SumW = CntW + 1;

  // control
  state_e            state_q, state_d;
  logic              commit;
  logic              accept;

  // captured word
  op_e               op_q;
  logic [ScanW-1:0]  scan_q;
  logic              down_q;
  logic [AsciiW-1:0] ascii_q;

  // architectural state
  logic              alias_q;
  logic              chain_q, chain_d;
  logic [FlagW-1:0]  flags_q, flags_d;
  logic              ctrl_q, ctrl_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;

  // ring memory
  logic [EntryW-1:0] ring_mem [RingDepth];
  logic [EntryW-1:0] rd_q;
  logic              wr_en;
  logic [IdxW-1:0]   tail;
  logic [SumW-1:0]   tail_sum;

  // result
  logic [ValueW-1:0] value;
  logic              ready_bit;
  logic              dropped;
  logic              toggle;
  logic              out_valid_q;
  logic [OutW-1:0]   out_data_q;

  key_res_t          dec;

  sktf_key_decode u_decode (
    .scan_i  (scan_q),
    .down_i  (down_q),
    .alias_i (alias_q),
    .chain_i (chain_q),
    .ctrl_i  (ctrl_q),
    .flags_i (flags_q),
    .res_o   (dec)
  );

  // FSM: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_EXEC;
      ST_EXEC: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: commit = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // tail = (head + count) mod depth; sum stays below twice the depth
  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(count_q);
    if (tail_sum >= SumW'(RingDepth)) tail_sum = tail_sum - SumW'(RingDepth);
    tail = IdxW'(tail_sum);
  end

  // execute: state update and result
  always_comb begin
    chain_d   = chain_q;
    flags_d   = flags_q;
    ctrl_d    = ctrl_q;
    head_d    = head_q;
    count_d   = count_q;
    wr_en     = 1'b0;
    value     = '0;
    ready_bit = 1'b0;
    dropped   = 1'b0;
    toggle    = 1'b0;
    unique case (op_q)
      OP_KEY: begin
        flags_d = dec.flags;
        ctrl_d  = dec.ctrl;
        toggle  = dec.toggle;
        if (dec.want_queue) begin
          if (count_q < CntW'(RingDepth)) begin
            wr_en   = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            dropped = 1'b1;
          end
        end
      end
      OP_PEEK, OP_POP: begin
        if (count_q != '0) begin
          ready_bit = 1'b1;
          // extended keys report 0x100 + scancode
          value = (rd_q[AsciiW-1:0] != '0) ? {1'b0, rd_q[AsciiW-1:0]}
                                           : {2'b10, rd_q[EntryW-1:AsciiW]};
          if (op_q == OP_POP) begin
            head_d  = (head_q == IdxW'(RingDepth - 1)) ? '0 : head_q + IdxW'(1);
            count_d = count_q - CntW'(1);
          end
        end
      end
      OP_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      OP_INSTALL: begin
        flags_d = '0;
        chain_d = 1'b0;
        head_d  = '0;
        count_d = '0;
      end
      default: ;  // unused codes only report status
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alias_q     <= 1'b0;
      chain_q     <= 1'b0;
      flags_q     <= '0;
      ctrl_q      <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        chain_q <= chain_d;
        flags_q <= flags_d;
        ctrl_q  <= ctrl_d;
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegAlias: alias_q <= cfg_data_i;
          RegChain: chain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (commit)             out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // captured word and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(s_axis_tuser);
      scan_q  <= s_axis_tdata[ScanW-1:0];
      down_q  <= s_axis_tdata[ScanW];
      ascii_q <= s_axis_tdata[InW-1:ScanW+1];
    end
    if (commit) begin
      out_data_q <= {3'b000, toggle, flags_d[FlagRel], flags_d[FlagDown], flags_d[FlagUpR],
                     flags_d[FlagUpL], flags_d[FlagUp], dropped, CountW'(count_d),
                     ready_bit, value};
    end
  end

  // ring memory: one write port at the tail, one registered read at the head
  always_ff @(posedge clk_i) begin
    if (commit && wr_en) ring_mem[tail] <= {scan_q, ascii_q};
    if (accept)          rd_q <= ring_mem[head_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/sktf_key_decode.sv =====
// Scancode decoder: direction flags, Ctrl tracking, sound toggle, queue request.
module sktf_key_decode (
  input  logic [sktf_pkg::ScanW-1:0] scan_i,
  input  logic                       down_i,
  input  logic                       alias_i,
  input  logic                       chain_i,
  input  logic                       ctrl_i,
  input  logic [sktf_pkg::FlagW-1:0] flags_i,
  output sktf_pkg::key_res_t         res_o
);
  import sktf_pkg::*;

  logic             handled;
  logic [FlagW-1:0] flags;
  logic             ctrl;
  logic             toggle;

  always_comb begin
    handled = 1'b1;
    flags   = flags_i;
    ctrl    = ctrl_i;
    toggle  = 1'b0;
    unique case (scan_i) inside
      ScHome, ScHomeAlt: begin
        if (scan_i == ScHome || alias_i) begin
          flags[FlagUp]  = down_i;
          flags[FlagUpL] = down_i;
          if (!down_i) flags[FlagRel] = 1'b1;
        end
      end
      ScPgUp: begin
        flags[FlagUp]  = down_i;
        flags[FlagUpR] = down_i;
        if (!down_i) flags[FlagRel] = 1'b1;
      end
      ScUp, ScUpAlt: begin
        if (scan_i == ScUp || alias_i) begin
          flags[FlagUp] = down_i;
          if (!down_i) flags[FlagRel] = 1'b1;
        end
      end
      ScLeft, ScLeftAlt: begin
        if (scan_i == ScLeft || alias_i) flags[FlagUpL] = down_i;
      end
      ScRight, ScRghtAlt: begin
        if (scan_i == ScRight || alias_i) flags[FlagUpR] = down_i;
      end
      ScDown, ScDownAlt: begin
        if (scan_i == ScDown || alias_i) flags[FlagDown] = down_i;
      end
      ScScroll, ScSysReq: begin
        handled = 1'b1;
      end
      ScS: begin
        if (ctrl_i && down_i) toggle = 1'b1;
        else handled = 1'b0;
      end
      ScCtrl: begin
        ctrl    = down_i;
        handled = 1'b0;
      end
      default: begin
        handled = 1'b0;
      end
    endcase
  end

  assign res_o.flags      = flags;
  assign res_o.ctrl       = ctrl;
  assign res_o.toggle     = toggle;
  assign res_o.want_queue = (!handled || chain_i) && down_i && !is_shift_key(scan_i);

endmodule

// ===== design/sktf_checker.sv =====
// Port-level checker for the key-state type-ahead block, bound to the top level.
`include "scancode_key_state_typeahead_fifo_defines.svh"

module sktf_checker #(
  parameter int unsigned RingDepth = sktf_pkg::RingDepthDef
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [sktf_pkg::InW-1:0]   s_axis_tdata,
  input logic [sktf_pkg::UserW-1:0] s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sktf_pkg::OutW-1:0]  m_axis_tdata,
  input logic                       cfg_we_i,
  input logic                       cfg_idx_i,
  input logic                       cfg_data_i
);
  import sktf_pkg::*;

  logic              s_fire;
  logic [ValueW-1:0] key_value;
  logic              key_ready;
  logic [CountW-1:0] entries;
  logic              dropped;
  logic              toggle;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign key_value = m_axis_tdata[ValueW-1:0];
  assign key_ready = m_axis_tdata[ValueW];
  assign entries   = m_axis_tdata[ValueW+CountW:ValueW+1];
  assign dropped   = m_axis_tdata[ValueW+CountW+1];
  assign toggle    = m_axis_tdata[ValueW+CountW+FlagW+2];

  // a stalled result word holds
  `SKTF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed under stall")
  // one word in flight: no accept right after an accept
  `SKTF_ASSERT_NEXT(a_one_in_flight, s_fire, !s_axis_tready, "input accepted back to back")
  // a ready key always reports a nonzero value, and no key means zero
  `SKTF_ASSERT_IMPL(a_value_ready, m_axis_tvalid, key_ready == (key_value != '0), "key_value and key_ready disagree")
  // a drop only happens with a full ring
  `SKTF_ASSERT_IMPL(a_drop_full, m_axis_tvalid && dropped, entries == CountW'(RingDepth) && !key_ready, "drop with ring not full")
  // sound toggle comes from a key event, never a peek or pop
  `SKTF_ASSERT_IMPL(a_toggle_key, m_axis_tvalid && toggle, !key_ready, "toggle on a read word")

endmodule

bind scancode_key_state_typeahead_fifo sktf_checker #(.RingDepth(RingDepth)) u_sktf_checker (.*);
